// ===== design/hfd_pkg.sv =====
// package for the humidity/temperature frame decoder: types, constants, crc function
`timescale 1ns / 1ps

package hfd_pkg;

    // byte position within a reply frame, one-hot
    typedef enum logic [2:0] {
        POS_HIGH = 3'b001,
        POS_LOW  = 3'b010,
        POS_CHK  = 3'b100
    } t_pos;

    // crc-8, x^8+x^5+x^4+1, msb first
    localparam logic [7:0] CRC_POLY = 8'h31;

    // mask that clears the status bits of the sensor code
    localparam logic [15:0] STATUS_MASK = 16'hFFFC;

    // conversion slopes over 2^16 and offsets, in hundredths
    localparam logic [14:0] TEMP_SLOPE  = 15'd17572;
    localparam logic [14:0] RH_SLOPE    = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4685;
    localparam logic [15:0] RH_OFFSET   = 16'd600;

    // one byte step of the crc, eight shift-xor steps
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/hfd_if.sv =====
// valid/ready channel interfaces for input bytes and decoded readings
`timescale 1ns / 1ps

interface hfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       is_humidity;

    modport source (output valid, output rx_byte, output is_humidity, input ready);
    modport sink   (input valid, input rx_byte, input is_humidity, output ready);
endinterface

interface hfd_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [15:0]        raw_code;
    logic signed [14:0] scaled_value;
    logic               crc_error;

    modport source (output valid, output kind, output raw_code, output scaled_value,
                    output crc_error, input ready);
    modport sink   (input valid, input kind, input raw_code, input scaled_value,
                    input crc_error, output ready);
endinterface

// ===== design/hfd_conv.sv =====
// converts a masked sensor code to hundredths of degC or %RH
`timescale 1ns / 1ps

module hfd_conv (
    input  logic               i_kind,
    input  logic [15:0]        i_code,
    output logic signed [14:0] o_value
);

    logic [14:0] slope;
    logic [15:0] offset;
    logic [30:0] product;
    logic [15:0] diff;

    // pick slope and offset by kind
    assign slope  = i_kind ? hfd_pkg::RH_SLOPE  : hfd_pkg::TEMP_SLOPE;
    assign offset = i_kind ? hfd_pkg::RH_OFFSET : hfd_pkg::TEMP_OFFSET;

    // floor(slope * code / 2^16) - offset
    assign product = {16'd0, slope} * {15'd0, i_code};
    assign diff    = {1'b0, product[30:16]} - offset;
    assign o_value = signed'(diff[14:0]);

endmodule

// ===== design/humidity_temp_frame_decoder.sv =====
// top level of the humidity/temperature reply frame decoder
//
//  channel   dir   modport   word
//  i_rx      in    sink      rx_byte[7:0], is_humidity
//  o_res     out   source    kind, raw_code[15:0], scaled_value[14:0], crc_error
//
// one word per cycle in, unless a stalled reading holds the input register.
// a checksum word sits in the input register, its reading in the result register.
// the crc byte step and the single 15x16 multiply sit between these registers.
// i_rst_n is synchronous and clears the frame position, crc and valid flags.
// a stalled reading holds the input register only when it carries a checksum
// word; data words keep flowing while a result waits.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hfd_in_if.sink     i_rx,
    hfd_out_if.source  o_res
);

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_kind;

    // frame state
    hfd_pkg::t_pos r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic        r_kind, n_kind;

    // result register
    logic               r_out_vld;
    logic               r_out_kind;
    logic [15:0]        r_out_code;
    logic signed [14:0] r_out_value;
    logic               r_out_err;

    logic        out_free;
    logic        in_adv;
    logic        in_take;
    logic        res_load;
    logic [15:0] code;
    logic signed [14:0] value;

    // flow control
    assign out_free = !r_out_vld || o_res.ready;
    assign in_adv   = !r_in_vld || (r_pos != hfd_pkg::POS_CHK) || out_free;
    assign in_take  = r_in_vld && in_adv;
    assign res_load = in_take && (r_pos == hfd_pkg::POS_CHK);
    assign i_rx.ready = in_adv;

    // masked code and conversion
    assign code = {r_high, r_low} & hfd_pkg::STATUS_MASK;

    hfd_conv u_conv (
        .i_kind  (r_kind),
        .i_code  (code),
        .o_value (value)
    );

    // frame position and crc update
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_high = r_high;
        n_low  = r_low;
        n_kind = r_kind;
        if (in_take) begin
            unique case (r_pos)
                hfd_pkg::POS_LOW: begin
                    n_low = r_in_byte;
                    n_crc = hfd_pkg::crc8_step(r_crc, r_in_byte);
                    n_pos = hfd_pkg::POS_CHK;
                end
                hfd_pkg::POS_CHK: begin
                    n_crc = 8'd0;
                    n_pos = hfd_pkg::POS_HIGH;
                end
                default: begin
                    n_high = r_in_byte;
                    n_kind = r_in_kind;
                    n_crc  = hfd_pkg::crc8_step(8'd0, r_in_byte);
                    n_pos  = hfd_pkg::POS_LOW;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pos     <= hfd_pkg::POS_HIGH;
            r_crc     <= 8'd0;
            r_high    <= 8'd0;
            r_low     <= 8'd0;
            r_kind    <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_vld <= i_rx.valid;
            end
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_high <= n_high;
            r_low  <= n_low;
            r_kind <= n_kind;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_kind <= i_rx.is_humidity;
        end
        if (res_load) begin
            r_out_kind  <= r_kind;
            r_out_code  <= code;
            r_out_value <= value;
            r_out_err   <= (r_crc != r_in_byte);
        end
    end

    // result channel
    assign o_res.valid        = r_out_vld;
    assign o_res.kind         = r_out_kind;
    assign o_res.raw_code     = r_out_code;
    assign o_res.scaled_value = r_out_value;
    assign o_res.crc_error    = r_out_err;

endmodule

// ===== design/hfd_chk.sv =====
// port checker for the frame decoder, bound to the top level
`timescale 1ns / 1ps

module hfd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_kind,
    input logic [15:0]        i_out_code,
    input logic signed [14:0] i_out_value,
    input logic               i_out_err
);

    // a stalled reading stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled reading keeps its word
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_kind) && $stable(i_out_code) &&
            $stable(i_out_value) && $stable(i_out_err))
        else $error("result word changed while stalled");

    // status bits are cleared
    a_code_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_code[1:0] == 2'b00)
        else $error("status bits not cleared");

    // converted value stays within the span of its kind
    a_value_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_kind && i_out_value >= -15'sd600 && i_out_value <= 15'sd11899) ||
            (!i_out_kind && i_out_value >= -15'sd4685 && i_out_value <= 15'sd12887))
        else $error("scaled value out of span");

endmodule

bind humidity_temp_frame_decoder hfd_chk u_hfd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.kind),
    .i_out_code  (o_res.raw_code),
    .i_out_value (o_res.scaled_value),
    .i_out_err   (o_res.crc_error)
);

// ===== dv/tb_humidity_temp_frame_decoder.sv =====
// self-checking testbench for the humidity/temperature reply frame decoder
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder;

    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // one input word and one decoded reading
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_humidity;
    } t_reply_word;

    typedef struct packed {
        logic               kind;
        logic [15:0]        raw_code;
        logic signed [14:0] scaled_value;
        logic               crc_error;
    } t_reading;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hfd_in_if  rx_if ();
    hfd_out_if res_if ();

    humidity_temp_frame_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_reply_word pending_words[$];
    t_reading    expected_readings[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // predictor state, cleared like the block at reset
    hfd_pkg::t_pos frame_pos  = hfd_pkg::POS_HIGH;
    logic [7:0]    run_crc    = 8'h00;
    logic [7:0]    high_byte  = 8'h00;
    logic [7:0]    low_byte   = 8'h00;
    logic          frame_kind = 1'b0;

    // driver and receiver pacing
    int          gap_left     = 0;
    int          burst_left   = 1;
    int          stall_left   = 0;
    logic [31:0] stall_pattern = '1;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // crc-8 poly 0x31, data bits fed msb first
    function automatic logic [7:0] crc8_after(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? hfd_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // advance the frame by one accepted word, queue a reading on the checksum word
    function automatic void decode_reply_word(input logic [7:0] b, input logic hum);
        t_reading    rd;
        logic [15:0] code;
        logic [31:0] prod;
        int          value;
        case (frame_pos)
            hfd_pkg::POS_LOW: begin
                low_byte  = b;
                run_crc   = crc8_after(run_crc, b);
                frame_pos = hfd_pkg::POS_CHK;
            end
            hfd_pkg::POS_CHK: begin
                code = {high_byte, low_byte} & hfd_pkg::STATUS_MASK;
                if (frame_kind) begin
                    prod  = 32'(hfd_pkg::RH_SLOPE) * 32'(code);
                    value = int'(prod[31:16]) - int'(hfd_pkg::RH_OFFSET);
                end else begin
                    prod  = 32'(hfd_pkg::TEMP_SLOPE) * 32'(code);
                    value = int'(prod[31:16]) - int'(hfd_pkg::TEMP_OFFSET);
                end
                rd.kind         = frame_kind;
                rd.raw_code     = code;
                rd.scaled_value = value[14:0];
                rd.crc_error    = (run_crc != b);
                expected_readings.push_back(rd);
                run_crc   = 8'h00;
                frame_pos = hfd_pkg::POS_HIGH;
            end
            default: begin
                // high word starts a frame and latches the kind
                high_byte  = b;
                frame_kind = hum;
                run_crc    = crc8_after(8'h00, b);
                frame_pos  = hfd_pkg::POS_LOW;
            end
        endcase
    endfunction

    function automatic logic [7:0] frame_crc(input logic [7:0] hi, input logic [7:0] lo);
        return crc8_after(crc8_after(8'h00, hi), lo);
    endfunction

    // kind of the high word, kind of the later two words
    function automatic void push_frame(input logic [7:0] hi, input logic [7:0] lo,
                                       input logic [7:0] chk, input logic k_first,
                                       input logic k_rest);
        pending_words.push_back('{hi, k_first});
        pending_words.push_back('{lo, k_rest});
        pending_words.push_back('{chk, k_rest});
    endfunction

    // word driver: bursts with random gaps, holds a word until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid       <= 1'b0;
            rx_if.rx_byte     <= 8'h00;
            rx_if.is_humidity <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                decode_reply_word(rx_if.rx_byte, rx_if.is_humidity);
                void'(pending_words.pop_front());
            end
            if (!(rx_if.valid && !rx_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_if.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    rx_if.valid       <= 1'b1;
                    rx_if.rx_byte     <= pending_words[0].rx_byte;
                    rx_if.is_humidity <= pending_words[0].is_humidity;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, reloaded now and then, never all stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom | 32'h1;
                    2:       stall_pattern = $urandom | $urandom;
                    default: stall_pattern = ($urandom & $urandom) | 32'h8000_0000;
                endcase
                stall_left = $urandom_range(16, 96);
            end else begin
                stall_pattern = {stall_pattern[30:0], stall_pattern[31]};
                stall_left--;
            end
            res_if.ready <= stall_pattern[0];
        end
    end

    // reading monitor, compared field by field with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_readings.size() == 0) begin
                flag_mismatch("reading with none expected");
            end else begin
                if (res_if.kind !== expected_readings[0].kind)
                    flag_mismatch($sformatf("kind %0b, expected %0b",
                                  res_if.kind, expected_readings[0].kind));
                if (res_if.raw_code !== expected_readings[0].raw_code)
                    flag_mismatch($sformatf("raw_code %h, expected %h",
                                  res_if.raw_code, expected_readings[0].raw_code));
                if (res_if.scaled_value !== expected_readings[0].scaled_value)
                    flag_mismatch($sformatf("scaled_value %0d, expected %0d",
                                  res_if.scaled_value, expected_readings[0].scaled_value));
                if (res_if.crc_error !== expected_readings[0].crc_error)
                    flag_mismatch($sformatf("crc_error %0b, expected %0b",
                                  res_if.crc_error, expected_readings[0].crc_error));
                void'(expected_readings.pop_front());
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] chk;
        int         sel;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = 8'h00;
        rx_if.is_humidity = 1'b0;
        res_if.ready      = 1'b0;

        // directed: code extremes for both kinds, good and bad checksums
        push_frame(8'h00, 8'h00, frame_crc(8'h00, 8'h00), 1'b0, 1'b0);
        push_frame(8'hFF, 8'hFF, frame_crc(8'hFF, 8'hFF), 1'b0, 1'b0);
        push_frame(8'h00, 8'h00, frame_crc(8'h00, 8'h00), 1'b1, 1'b1);
        push_frame(8'hFF, 8'hFF, frame_crc(8'hFF, 8'hFF) ^ 8'hFF, 1'b1, 1'b1);
        // kind flips after the high word and must be ignored
        push_frame(8'h80, 8'h03, frame_crc(8'h80, 8'h03), 1'b1, 1'b0);
        push_frame(8'h7F, 8'hFC, frame_crc(8'h7F, 8'hFC) ^ 8'h01, 1'b0, 1'b1);
        // checksum word at its extremes
        push_frame(8'h55, 8'hAA, 8'hFF, 1'b1, 1'b0);
        push_frame(8'hAA, 8'h55, 8'h00, 1'b0, 1'b1);

        // random: mostly well-formed frames, some corrupted, some loose words
        while (pending_words.size() < RANDOM_ITEMS + 24) begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       hi = 8'h00;
                1:       hi = 8'hFF;
                default: hi = 8'($urandom_range(0, 255));
            endcase
            lo = 8'($urandom_range(0, 255));
            if (sel < 80) begin
                chk = frame_crc(hi, lo);
                push_frame(hi, lo, chk, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (sel < 92) begin
                chk = frame_crc(hi, lo) ^ 8'($urandom_range(1, 255));
                push_frame(hi, lo, chk, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else begin
                // loose words shift the frame alignment
                repeat ($urandom_range(1, 2))
                    pending_words.push_back('{8'($urandom_range(0, 255)),
                                             1'($urandom_range(0, 1))});
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || rx_if.valid) @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
